// ----- rtl/core/hrsp_pkg.sv -----
// Shared types, codes and tables of the HTTP request stream parser.
package hrsp_pkg;

  typedef enum logic [2:0] {
    PART_DELIM   = 3'd0,
    PART_METHOD  = 3'd1,
    PART_URL     = 3'd2,
    PART_VERSION = 3'd3,
    PART_NAME    = 3'd4,
    PART_VALUE   = 3'd5,
    PART_BODY    = 3'd6,
    PART_HELD    = 3'd7
  } part_e;

  typedef enum logic [3:0] {
    EV_NONE         = 4'd0,
    EV_LINE_DONE    = 4'd1,
    EV_HEADER_DONE  = 4'd2,
    EV_HEADERS_DONE = 4'd3,
    EV_REQUEST_DONE = 4'd4,
    EV_BAD_LINE     = 4'd5,
    EV_BAD_HEADER   = 4'd6,
    EV_BAD_BODY     = 4'd7,
    EV_TOO_LARGE    = 4'd8
  } event_e;

  localparam logic [31:0] MaxBodyReset = 32'd1048576;
  localparam logic [3:0]  KeyLen       = 4'd14;
  localparam logic [3:0]  MatchNone    = 4'd15;
  localparam logic [63:0] LenLimit     = 64'h1999_9999_9999_9999;
  localparam logic [3:0]  LenLimitDig  = 4'd5;

  typedef struct packed {
    logic [7:0] data;
    logic       sor;
    logic       is_cr;
    logic       is_lf;
    logic       is_sp;
    logic       is_colon;
    logic       is_ws;
    logic       is_digit;
    logic [3:0] digit;
    logic [7:0] lower;
  } item_t;

  function automatic logic [7:0] key_char(input logic [3:0] pos);
    logic [7:0] c;
    unique case (pos)
      4'd0:    c = "c";
      4'd1:    c = "o";
      4'd2:    c = "n";
      4'd3:    c = "t";
      4'd4:    c = "e";
      4'd5:    c = "n";
      4'd6:    c = "t";
      4'd7:    c = "-";
      4'd8:    c = "l";
      4'd9:    c = "e";
      4'd10:   c = "n";
      4'd11:   c = "g";
      4'd12:   c = "t";
      4'd13:   c = "h";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/core/hrsp_front.sv -----
// Front end: accepts request bytes and classifies them for the back end.
module hrsp_front (
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [7:0]     data_byte_i,
  input  logic           start_of_request_i,
  input  logic           q_full_i,
  output logic           push_o,
  output hrsp_pkg::item_t item_o
);
  import hrsp_pkg::*;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    item_o.data     = data_byte_i;
    item_o.sor      = start_of_request_i;
    item_o.is_cr    = (data_byte_i == 8'h0d);
    item_o.is_lf    = (data_byte_i == 8'h0a);
    item_o.is_sp    = (data_byte_i == 8'h20);
    item_o.is_colon = (data_byte_i == 8'h3a);
    item_o.is_ws    = (data_byte_i == 8'h20) || (data_byte_i == 8'h09);
    item_o.is_digit = (data_byte_i >= 8'h30) && (data_byte_i <= 8'h39);
    item_o.digit    = 4'(data_byte_i - 8'h30);
    if ((data_byte_i >= 8'h41) && (data_byte_i <= 8'h5a)) begin
      item_o.lower = data_byte_i + 8'd32;
    end else begin
      item_o.lower = data_byte_i;
    end
  end

endmodule

// ----- rtl/core/hrsp_fifo.sv -----
// Two-entry queue between the front and back ends.
module hrsp_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  hrsp_pkg::item_t item_i,
  output logic            full_o,
  output logic            valid_o,
  input  logic            pop_i,
  output hrsp_pkg::item_t item_o
);
  import hrsp_pkg::*;

  item_t      mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign item_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) wptr_q <= !wptr_q;
      if (pop_i) rptr_q <= !rptr_q;
      count_q <= count_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

// ----- rtl/core/hrsp_back.sv -----
// Back end: request parsing state machine and output register.
module hrsp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [31:0]     max_body_i,
  input  logic            q_valid_i,
  input  hrsp_pkg::item_t item_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      byte_out_o,
  output logic [2:0]      part_o,
  output logic            held_is_content_o,
  output logic [3:0]      event_res_o,
  output logic [31:0]     body_length_o
);
  import hrsp_pkg::*;

  typedef enum logic [8:0] {
    PH_METHOD     = 9'b000000001,
    PH_URL        = 9'b000000010,
    PH_VERSION    = 9'b000000100,
    PH_NAME_START = 9'b000001000,
    PH_NAME       = 9'b000010000,
    PH_VALUE      = 9'b000100000,
    PH_BODY       = 9'b001000000,
    PH_DONE       = 9'b010000000,
    PH_FAILED     = 9'b100000000
  } phase_e;

  typedef enum logic [1:0] {HELD_NONE, HELD_CR, HELD_COLON} held_e;
  typedef enum logic [1:0] {SCAN_LEAD, SCAN_DIGITS, SCAN_TRAIL, SCAN_BAD} scan_e;

  phase_e      phase_q, phase_d;
  held_e       held_q, held_d;
  logic [1:0]  sc_q, sc_d;
  logic        ms_q, ms_d, us_q, us_d, vs_q, vs_d;
  logic [3:0]  nmp_q, nmp_d;
  logic        lf_q, lf_d;
  scan_e       scan_q, scan_d;
  logic [63:0] lv_q, lv_d;
  logic        lo_q, lo_d;
  logic [31:0] br_q, br_d;

  logic        out_valid_q;
  logic [7:0]  byte_q;
  part_e       part_q, part_d;
  logic        hc_q, hc_d;
  event_e      ev_q, ev_d;
  logic [31:0] blen_q, blen_d;

  logic        fin;
  logic [63:0] lv_next;

  assign pop_o   = q_valid_i && (!out_valid_q || out_ready_i);
  assign lv_next = (lv_q << 3) + (lv_q << 1) + 64'(item_i.digit);

  always_comb begin
    phase_d = phase_q; held_d = held_q; sc_d = sc_q;
    ms_d = ms_q; us_d = us_q; vs_d = vs_q;
    nmp_d = nmp_q; lf_d = lf_q; scan_d = scan_q;
    lv_d = lv_q; lo_d = lo_q; br_d = br_q;
    part_d = PART_DELIM; hc_d = 1'b0; ev_d = EV_NONE; blen_d = 32'd0;
    fin = 1'b0;

    if (item_i.sor) begin
      phase_d = PH_METHOD; held_d = HELD_NONE; sc_d = 2'd0;
      ms_d = 1'b0; us_d = 1'b0; vs_d = 1'b0;
      nmp_d = 4'd0; lf_d = 1'b0; scan_d = SCAN_LEAD;
      lv_d = 64'd0; lo_d = 1'b0; br_d = 32'd0;
    end

    if (held_d == HELD_CR) begin
      held_d = HELD_NONE;
      if (item_i.is_lf) begin
        fin = 1'b1;
        unique case (phase_d)
          PH_METHOD, PH_URL, PH_VERSION: begin
            if (sc_d == 2'd2 && ms_d && us_d && vs_d) begin
              phase_d = PH_NAME_START;
              ev_d    = EV_LINE_DONE;
            end else begin
              phase_d = PH_FAILED;
              ev_d    = EV_BAD_LINE;
            end
          end
          PH_NAME: begin
            phase_d = PH_FAILED;
            ev_d    = EV_BAD_HEADER;
          end
          PH_VALUE: begin
            phase_d = PH_NAME_START;
            nmp_d   = 4'd0;
            ev_d    = EV_HEADER_DONE;
          end
          default: begin
            priority if (!lf_d) begin
              phase_d = PH_DONE;
              ev_d    = EV_REQUEST_DONE;
            end else if (scan_d == SCAN_LEAD || scan_d == SCAN_BAD || lo_d) begin
              phase_d = PH_FAILED;
              ev_d    = EV_BAD_BODY;
            end else if (lv_d > {32'd0, max_body_i}) begin
              phase_d = PH_FAILED;
              ev_d    = EV_TOO_LARGE;
            end else if (lv_d == 64'd0) begin
              phase_d = PH_DONE;
              ev_d    = EV_REQUEST_DONE;
            end else begin
              blen_d  = lv_d[31:0];
              br_d    = lv_d[31:0];
              phase_d = PH_BODY;
              ev_d    = EV_HEADERS_DONE;
            end
          end
        endcase
      end else begin
        hc_d = 1'b1;
        unique case (phase_d)
          PH_METHOD:  ms_d = 1'b1;
          PH_URL:     us_d = 1'b1;
          PH_VERSION: vs_d = 1'b1;
          PH_NAME_START, PH_NAME: begin
            nmp_d   = MatchNone;
            phase_d = PH_NAME;
          end
          PH_VALUE: if (nmp_d == KeyLen) scan_d = SCAN_BAD;
          default: ;
        endcase
      end
    end else if (held_d == HELD_COLON) begin
      held_d = HELD_NONE;
      if (item_i.is_sp) begin
        if (nmp_d == KeyLen && !lf_d) lf_d = 1'b1;
        else nmp_d = MatchNone;
        phase_d = PH_VALUE;
        fin     = 1'b1;
      end else begin
        hc_d    = 1'b1;
        nmp_d   = MatchNone;
        phase_d = PH_NAME;
      end
    end

    if (!fin) begin
      unique case (phase_d)
        PH_METHOD, PH_URL, PH_VERSION: begin
          priority if (item_i.is_cr) begin
            held_d = HELD_CR;
            part_d = PART_HELD;
          end else if (item_i.is_sp && phase_d != PH_VERSION) begin
            phase_d = (phase_d == PH_METHOD) ? PH_URL : PH_VERSION;
            sc_d    = sc_d + 2'd1;
          end else if (phase_d == PH_METHOD) begin
            part_d = PART_METHOD;
            ms_d   = 1'b1;
          end else if (phase_d == PH_URL) begin
            part_d = PART_URL;
            us_d   = 1'b1;
          end else begin
            part_d = PART_VERSION;
            vs_d   = 1'b1;
          end
        end
        PH_NAME_START, PH_NAME: begin
          priority if (item_i.is_cr) begin
            held_d = HELD_CR;
            part_d = PART_HELD;
          end else if (item_i.is_colon) begin
            held_d = HELD_COLON;
            part_d = PART_HELD;
          end else begin
            part_d  = PART_NAME;
            phase_d = PH_NAME;
            if (nmp_d < KeyLen && item_i.lower == key_char(nmp_d)) nmp_d = nmp_d + 4'd1;
            else nmp_d = MatchNone;
          end
        end
        PH_VALUE: begin
          if (item_i.is_cr) begin
            held_d = HELD_CR;
            part_d = PART_HELD;
          end else begin
            part_d = PART_VALUE;
            if (nmp_d == KeyLen) begin
              unique case (scan_d)
                SCAN_LEAD: begin
                  if (item_i.is_digit) scan_d = SCAN_DIGITS;
                  else if (!item_i.is_ws) scan_d = SCAN_BAD;
                end
                SCAN_DIGITS: begin
                  if (item_i.is_ws) scan_d = SCAN_TRAIL;
                  else if (!item_i.is_digit) scan_d = SCAN_BAD;
                end
                default: if (!item_i.is_ws) scan_d = SCAN_BAD;
              endcase
              if (item_i.is_digit && scan_d == SCAN_DIGITS && !lo_d) begin
                if (lv_d > LenLimit || (lv_d == LenLimit && item_i.digit > LenLimitDig)) begin
                  lo_d = 1'b1;
                end else begin
                  lv_d = lv_next;
                end
              end
            end
          end
        end
        PH_BODY: begin
          part_d = PART_BODY;
          if (br_d > 32'd0) br_d = br_d - 32'd1;
          if (br_d == 32'd0) begin
            phase_d = PH_DONE;
            ev_d    = EV_REQUEST_DONE;
            blen_d  = lv_d[31:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_METHOD; held_q <= HELD_NONE; sc_q <= 2'd0;
      ms_q <= 1'b0; us_q <= 1'b0; vs_q <= 1'b0;
      nmp_q <= 4'd0; lf_q <= 1'b0; scan_q <= SCAN_LEAD;
      lv_q <= 64'd0; lo_q <= 1'b0; br_q <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q <= phase_d; held_q <= held_d; sc_q <= sc_d;
        ms_q <= ms_d; us_q <= us_d; vs_q <= vs_d;
        nmp_q <= nmp_d; lf_q <= lf_d; scan_q <= scan_d;
        lv_q <= lv_d; lo_q <= lo_d; br_q <= br_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      byte_q <= item_i.data;
      part_q <= part_d;
      hc_q   <= hc_d;
      ev_q   <= ev_d;
      blen_q <= blen_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign byte_out_o        = byte_q;
  assign part_o            = part_q;
  assign held_is_content_o = hc_q;
  assign event_res_o       = ev_q;
  assign body_length_o     = blen_q;

  a_held_no_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && part_q == PART_HELD |-> ev_q == EV_NONE)
    else $error("held byte carries an event");
  a_blen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && ev_q != EV_HEADERS_DONE && ev_q != EV_REQUEST_DONE |-> blen_q == 32'd0)
    else $error("body length outside end events");
  a_content_no_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && hc_q |-> ev_q == EV_NONE)
    else $error("held content with event");
  a_body_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_BODY |-> br_q != 32'd0)
    else $error("body phase with nothing left");

endmodule

// ----- rtl/core/http_request_stream_parser.sv -----
// Top level of the HTTP request stream parser.
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one request byte per
//   transaction with start_of_request_i marking the first byte of a request.
//   Output channel (out_valid_o/out_ready_i) gives one transaction per input
//   byte: the byte echoed, its part tag, the held-content flag, an event code
//   and the declared body length with the headers-done and request-done events.
//   cfg_we_i/cfg_wdata_i write the maximum body length; write only when idle.
// Path: an accepted byte is first written into the queue, then parsed by the
//   back end into the output register.
// Throughput: one byte per cycle while out_ready_i is high, set by the
//   combinational parse step of the back-end state machine.
// Reset: clears the queue, the output register and all parse state; the
//   maximum body length returns to 1048576.
// Stall: when out_ready_i is low the output holds, the back end stops, and
//   the two-entry queue fills before in_ready_o drops.
module http_request_stream_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        start_of_request_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  byte_out_o,
  output logic [2:0]  part_o,
  output logic        held_is_content_o,
  output logic [3:0]  event_res_o,
  output logic [31:0] body_length_o
);
  import hrsp_pkg::*;

  logic [31:0] max_body_q;
  logic        push, full, q_valid, pop;
  item_t       push_item, q_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_body_q <= MaxBodyReset;
    end else if (cfg_we_i) begin
      max_body_q <= cfg_wdata_i;
    end
  end

  hrsp_front u_front (
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .data_byte_i        (data_byte_i),
    .start_of_request_i (start_of_request_i),
    .q_full_i           (full),
    .push_o             (push),
    .item_o             (push_item)
  );

  hrsp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .item_o  (q_item)
  );

  hrsp_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .max_body_i        (max_body_q),
    .q_valid_i         (q_valid),
    .item_i            (q_item),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .byte_out_o        (byte_out_o),
    .part_o            (part_o),
    .held_is_content_o (held_is_content_o),
    .event_res_o       (event_res_o),
    .body_length_o     (body_length_o)
  );

endmodule
